/* rtl/rpsb_pkg.sv */
// ----------------------------------------------------------------------------
// Radial power spectrum binner package
// Shared types, widths and codes for the binner front end, queue and back end.
// ----------------------------------------------------------------------------
package rpsb_pkg;

   // Default geometry of the Fourier grid and the number of radial bins.
   localparam int DEF_GRID_X   = 256;
   localparam int DEF_GRID_Y   = 256;
   localparam int DEF_NUM_BINS = 256;

   // Field widths.
   localparam int INDEX_W = 8;
   localparam int COEF_W  = 16;
   localparam int SCALE_W = 17;
   localparam int FREQ_W  = 8;
   localparam int PROD_W  = SCALE_W + FREQ_W;
   localparam int SQ_W    = 2 * PROD_W;
   localparam int POWER_W = 32;
   localparam int SUM_W   = 48;

   // The bin is isqrt(S) >> 16, which equals isqrt(S >> 32).
   localparam int RAD_SHIFT = 32;
   localparam int ROOT_W    = 10;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int REM_W     = ROOT_W + 3;

   // Reset value of both scale registers (1.0 in Q1.16).
   localparam logic [SCALE_W-1:0] SCALE_ONE = 17'h10000;

   // Saturation value of a bin.
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // Depth of the command queue between the front and back ends.
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_X_SCALE = 2'd0;
   localparam logic [1:0] CSR_Y_SCALE = 2'd1;

   // Operation codes.
   typedef enum logic [1:0] {
      OP_ACCUMULATE = 2'd0,
      OP_READ       = 2'd1,
      OP_CLEAR      = 2'd2
   } op_type;

   // Command handed from the front end to the back end.
   typedef struct packed {
      op_type                   op;
      logic [INDEX_W-1:0]       bin;
      logic [RAD_W-1:0]         radicand;
      logic [POWER_W-1:0]       power;
   } cmd_type;

   // Front end sequencer states.
   typedef enum logic [2:0] {
      F_IDLE,
      F_REDUCE,
      F_SCALE,
      F_SQUARE,
      F_PUSH
   } front_state_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      B_IDLE,
      B_ROOT,
      B_FETCH,
      B_APPLY
   } back_state_type;

endpackage

/* rtl/radial_power_spectrum_binner_unit.sv */
// ----------------------------------------------------------------------------
// Radial power spectrum binner
// Accumulates coefficient power into radial wavenumber bins, reads and clears.
// ----------------------------------------------------------------------------
// Usage:
// - The req_ channel carries one transaction: accumulate a coefficient at a
//   grid position, read one bin, or clear all bins.
// - The rsp_ channel returns one transaction for each read: the bin's
//   saturated power and the bin number actually read.
// - The csr_ channel writes the x and y scale registers (Q1.16); csr_ready
//   is always high. Write them only while the block is idle.
// - Occupancy: an accumulate holds the back end through the ten-step square
//   root, which yields the bin index one bit per cycle, then a fetch and an
//   apply step; a read needs the fetch and apply steps, and a clear is done
//   when it is taken. The front end takes each transaction through its reduce,
//   scale, square and push states; a four-entry queue lets it run ahead.
// - A read passes the front end states, the queue, the back end fetch and apply steps and the result register.
// - Reset clears every bin at once through per-bin valid flags; there is no
//   clearing pass. Scales return to 1.0.
// - A stalled receiver holds the result in the output register; the block
//   keeps accepting requests until the queue fills.
// ----------------------------------------------------------------------------
module radial_power_spectrum_binner_unit import rpsb_pkg::*; #(
   parameter int GRID_X   = DEF_GRID_X,
   parameter int GRID_Y   = DEF_GRID_Y,
   parameter int NUM_BINS = DEF_NUM_BINS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [INDEX_W-1:0]        req_row_index,
   input  logic [INDEX_W-1:0]        req_column_index,
   input  logic signed [COEF_W-1:0]  req_real_part,
   input  logic signed [COEF_W-1:0]  req_imag_part,
   input  logic [INDEX_W-1:0]        req_read_bin,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SUM_W-1:0]          rsp_bin_power,
   output logic [INDEX_W-1:0]        rsp_bin_number,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [SCALE_W-1:0]        csr_wdata
);

   logic [SCALE_W-1:0] x_scale_ff, y_scale_ff;
   logic               enq_valid, enq_ready, deq_valid, deq_ready;
   cmd_type            enq_data, deq_data;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff <= SCALE_ONE;
         y_scale_ff <= SCALE_ONE;
      end else if (csr_valid) begin
         if (csr_index == CSR_X_SCALE) begin
            x_scale_ff <= csr_wdata;
         end else if (csr_index == CSR_Y_SCALE) begin
            y_scale_ff <= csr_wdata;
         end
      end
   end

   // Front end: acceptance and radius and power arithmetic.
   rpsb_front #(
      .GRID_X   (GRID_X),
      .GRID_Y   (GRID_Y),
      .NUM_BINS (NUM_BINS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .x_scale          (x_scale_ff),
      .y_scale          (y_scale_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_row_index    (req_row_index),
      .req_column_index (req_column_index),
      .req_real_part    (req_real_part),
      .req_imag_part    (req_imag_part),
      .req_read_bin     (req_read_bin),
      .enq_valid        (enq_valid),
      .enq_ready        (enq_ready),
      .enq_data         (enq_data)
   );

   // Command queue.
   rpsb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (enq_valid),
      .enq_ready (enq_ready),
      .enq_data  (enq_data),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_data  (deq_data)
   );

   // Back end: square root, bin memory and result register.
   rpsb_back #(
      .NUM_BINS (NUM_BINS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .deq_valid      (deq_valid),
      .deq_ready      (deq_ready),
      .deq_data       (deq_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bin_power  (rsp_bin_power),
      .rsp_bin_number (rsp_bin_number)
   );

endmodule

/* rtl/rpsb_front.sv */
// ----------------------------------------------------------------------------
// Radial power spectrum binner front end
// Accepts transactions, folds grid indexes into frequencies, forms the squared
// radius and the coefficient power, and queues a command for the back end.
// ----------------------------------------------------------------------------
module rpsb_front import rpsb_pkg::*; #(
   parameter int GRID_X   = DEF_GRID_X,
   parameter int GRID_Y   = DEF_GRID_Y,
   parameter int NUM_BINS = DEF_NUM_BINS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [SCALE_W-1:0]        x_scale,
   input  logic [SCALE_W-1:0]        y_scale,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [INDEX_W-1:0]        req_row_index,
   input  logic [INDEX_W-1:0]        req_column_index,
   input  logic signed [COEF_W-1:0]  req_real_part,
   input  logic signed [COEF_W-1:0]  req_imag_part,
   input  logic [INDEX_W-1:0]        req_read_bin,
   output logic                      enq_valid,
   input  logic                      enq_ready,
   output cmd_type                   enq_data
);

   // Reciprocals for the index reduction: floor(i / G) = (i * R) >> 17 for i < 256.
   localparam int RECIP_SHIFT = 17;
   localparam logic [15:0] RECIP_X = 16'(((2 ** RECIP_SHIFT) + GRID_X - 1) / GRID_X);
   localparam logic [15:0] RECIP_Y = 16'(((2 ** RECIP_SHIFT) + GRID_Y - 1) / GRID_Y);
   localparam logic [8:0]  GX      = 9'(GRID_X);
   localparam logic [8:0]  GY      = 9'(GRID_Y);
   localparam logic [8:0]  HALF_X  = 9'(GRID_X / 2);
   localparam logic [8:0]  HALF_Y  = 9'(GRID_Y / 2);
   localparam logic [8:0]  LAST_BIN = 9'(NUM_BINS - 1);

   front_state_type state_ff, state_in;

   logic                       accept;
   logic                       load_reduce;
   logic                       load_scale;
   logic                       load_square;

   op_type                     op_ff;
   logic [INDEX_W-1:0]         row_ff, col_ff, bin_ff;
   logic signed [COEF_W-1:0]   re_ff, im_ff;
   logic [FREQ_W-1:0]          fx_ff, fy_ff;
   logic [PROD_W-1:0]          px_ff, py_ff;
   logic [2*COEF_W-1:0]        re2_ff, im2_ff;
   logic [SQ_W-1:0]            sx_ff, sy_ff;
   logic [POWER_W-1:0]         pw_ff;

   logic [INDEX_W-1:0]         bin_in;
   logic [23:0]                qx_prod, qy_prod;
   logic [15:0]                qgx, qgy;
   logic [8:0]                 rx, ry, fx_wide, fy_wide;
   logic [SQ_W:0]              radius_sq;
   logic signed [2*COEF_W-1:0] re2_s, im2_s;

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:   if (req_valid) state_in = F_REDUCE;
         F_REDUCE: state_in = F_SCALE;
         F_SCALE:  state_in = F_SQUARE;
         F_SQUARE: state_in = F_PUSH;
         F_PUSH:   if (enq_ready) state_in = F_IDLE;
         default:  state_in = F_IDLE;
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      req_ready   = 1'b0;
      load_reduce = 1'b0;
      load_scale  = 1'b0;
      load_square = 1'b0;
      enq_valid   = 1'b0;
      unique case (state_ff)
         F_IDLE:   req_ready   = 1'b1;
         F_REDUCE: load_reduce = 1'b1;
         F_SCALE:  load_scale  = 1'b1;
         F_SQUARE: load_square = 1'b1;
         F_PUSH:   enq_valid   = 1'b1;
         default:  req_ready   = 1'b0;
      endcase
   end

   assign accept = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A read past the last bin reads the last bin.
   assign bin_in = ({1'b0, req_read_bin} > LAST_BIN) ? LAST_BIN[INDEX_W-1:0] : req_read_bin;

   // Periodic reduction of the indexes, then fold the upper half to negative frequency.
   always_comb begin
      qx_prod = 24'(row_ff) * 24'(RECIP_X);
      qy_prod = 24'(col_ff) * 24'(RECIP_Y);
      qgx     = 16'(qx_prod[23:RECIP_SHIFT]) * 16'(GX);
      qgy     = 16'(qy_prod[23:RECIP_SHIFT]) * 16'(GY);
      rx      = 9'(row_ff) - qgx[8:0];
      ry      = 9'(col_ff) - qgy[8:0];
      fx_wide = (rx >= HALF_X) ? (GX - rx) : rx;
      fy_wide = (ry >= HALF_Y) ? (GY - ry) : ry;
   end

   // Coefficient squares are non-negative and fit in 31 bits.
   assign re2_s = re_ff * re_ff;
   assign im2_s = im_ff * im_ff;

   // Squared radius in units of 2^-32.
   assign radius_sq = {1'b0, sx_ff} + {1'b0, sy_ff};

   // Datapath registers, one step per sequencer state.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_opcode);
         row_ff <= req_row_index;
         col_ff <= req_column_index;
         re_ff  <= req_real_part;
         im_ff  <= req_imag_part;
         bin_ff <= bin_in;
      end
      if (load_reduce) begin
         fx_ff <= fx_wide[FREQ_W-1:0];
         fy_ff <= fy_wide[FREQ_W-1:0];
      end
      if (load_scale) begin
         px_ff  <= PROD_W'(x_scale) * PROD_W'(fx_ff);
         py_ff  <= PROD_W'(y_scale) * PROD_W'(fy_ff);
         re2_ff <= re2_s;
         im2_ff <= im2_s;
      end
      if (load_square) begin
         sx_ff <= SQ_W'(px_ff) * SQ_W'(px_ff);
         sy_ff <= SQ_W'(py_ff) * SQ_W'(py_ff);
         pw_ff <= re2_ff + im2_ff;
      end
   end

   // Command toward the back end.
   always_comb begin
      enq_data.op       = op_ff;
      enq_data.bin      = bin_ff;
      enq_data.radicand = RAD_W'(radius_sq[SQ_W:RAD_SHIFT]);
      enq_data.power    = pw_ff;
   end

endmodule

/* rtl/rpsb_queue.sv */
// ----------------------------------------------------------------------------
// Radial power spectrum binner command queue
// Small first-in first-out buffer that decouples the front and back ends.
// ----------------------------------------------------------------------------
module rpsb_queue import rpsb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    enq_valid,
   output logic    enq_ready,
   input  cmd_type enq_data,
   output logic    deq_valid,
   input  logic    deq_ready,
   output cmd_type deq_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   head_ff, tail_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               push, pop;

   assign enq_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign deq_valid = (count_ff != '0);
   assign push      = enq_valid & enq_ready;
   assign pop       = deq_valid & deq_ready;
   assign deq_data  = slot_ff[head_ff];

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= enq_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) tail_ff <= tail_ff + 1'b1;
         if (pop)  head_ff <= head_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* rtl/rpsb_back.sv */
// ----------------------------------------------------------------------------
// Radial power spectrum binner back end
// Takes the radial bin by an iterative square root, updates the bin memory
// with saturation, serves bin reads and clears all bins.
// ----------------------------------------------------------------------------
module rpsb_back import rpsb_pkg::*; #(
   parameter int NUM_BINS = DEF_NUM_BINS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                deq_valid,
   output logic                deq_ready,
   input  cmd_type             deq_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SUM_W-1:0]    rsp_bin_power,
   output logic [INDEX_W-1:0]  rsp_bin_number
);

   localparam int BIN_W = $clog2(NUM_BINS);
   localparam int CNT_W = $clog2(ROOT_W);
   localparam logic [ROOT_W-1:0] LAST_ROOT = ROOT_W'(NUM_BINS - 1);

   back_state_type state_ff, state_in;

   cmd_type            cmd_ff;
   logic [RAD_W-1:0]   rad_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [CNT_W-1:0]   count_ff;

   logic [SUM_W-1:0]   bin_mem [NUM_BINS];
   logic [NUM_BINS-1:0] valid_ff;
   logic [SUM_W-1:0]   rd_data_ff;
   logic               rd_valid_ff;
   logic [BIN_W-1:0]   addr_ff;

   logic               rsp_valid_ff;
   logic [SUM_W-1:0]   bin_power_ff;
   logic [INDEX_W-1:0] bin_number_ff;

   logic               pop, root_step, mem_fetch, mem_write, rsp_load, rsp_free;
   logic [REM_W-1:0]   rem_shift, trial;
   logic               fits;
   logic [BIN_W-1:0]   fetch_addr;
   logic [SUM_W-1:0]   old_sum;
   logic [SUM_W:0]     new_sum;

   assign rsp_free = ~rsp_valid_ff | rsp_ready;

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (deq_valid) begin
               if (deq_data.op == OP_ACCUMULATE) begin
                  state_in = B_ROOT;
               end else if (deq_data.op == OP_READ) begin
                  state_in = B_FETCH;
               end
            end
         end
         B_ROOT:  if (count_ff == '0) state_in = B_FETCH;
         B_FETCH: state_in = B_APPLY;
         B_APPLY: if (cmd_ff.op != OP_READ || rsp_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      pop       = 1'b0;
      root_step = 1'b0;
      mem_fetch = 1'b0;
      mem_write = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         B_IDLE:  pop       = deq_valid;
         B_ROOT:  root_step = 1'b1;
         B_FETCH: mem_fetch = 1'b1;
         B_APPLY: begin
            mem_write = (cmd_ff.op == OP_ACCUMULATE);
            rsp_load  = (cmd_ff.op == OP_READ) & rsp_free;
         end
         default: pop = 1'b0;
      endcase
   end

   assign deq_ready = (state_ff == B_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // One result bit per cycle of the restoring square root.
   always_comb begin
      rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      fits      = (rem_shift >= trial);
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff   <= deq_data;
         rad_ff   <= deq_data.radicand;
         rem_ff   <= '0;
         root_ff  <= '0;
         count_ff <= CNT_W'(ROOT_W - 1);
      end else if (root_step) begin
         rad_ff   <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff   <= fits ? (rem_shift - trial) : rem_shift;
         root_ff  <= {root_ff[ROOT_W-2:0], fits};
         count_ff <= count_ff - 1'b1;
      end
   end

   // Radii past the last bin land in the last bin.
   always_comb begin
      if (cmd_ff.op == OP_READ) begin
         fetch_addr = cmd_ff.bin[BIN_W-1:0];
      end else if (root_ff > LAST_ROOT) begin
         fetch_addr = LAST_ROOT[BIN_W-1:0];
      end else begin
         fetch_addr = root_ff[BIN_W-1:0];
      end
   end

   // Bin memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_fetch) begin
         rd_data_ff <= bin_mem[fetch_addr];
         addr_ff    <= fetch_addr;
      end
      if (mem_write) begin
         bin_mem[addr_ff] <= new_sum[SUM_W] ? SUM_MAX : new_sum[SUM_W-1:0];
      end
   end

   // Per-bin valid flags: a bin never written since reset or a clear reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_fetch) begin
            rd_valid_ff <= valid_ff[fetch_addr];
         end
         if (pop && deq_data.op == OP_CLEAR) begin
            valid_ff <= '0;
         end else if (mem_write) begin
            valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   // Saturating accumulation.
   assign old_sum = rd_valid_ff ? rd_data_ff : '0;
   assign new_sum = {1'b0, old_sum} + (SUM_W + 1)'(cmd_ff.power);

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         bin_power_ff  <= old_sum;
         bin_number_ff <= INDEX_W'(addr_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_power  = bin_power_ff;
   assign rsp_bin_number = bin_number_ff;

endmodule
